// ===== sv/u8u32_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u32_pkg: shared types for the UTF-8 to UTF-32 padded row decoder
// Result kinds, error codes, controller states and the control/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package u8u32_pkg;

  localparam int unsigned CountW       = 6;   // code points per string
  localparam int unsigned PointW       = 21;  // UTF-32 code point width
  localparam int unsigned ByteW        = 8;
  localparam int unsigned RowWidthMax  = 63;  // default row width bound
  localparam logic [CountW-1:0] RowWidthReset = 6'd63;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_PAD   = 2'd1,
    KIND_EOR   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TRUNCATED = 2'd1,
    ERR_TOO_MANY  = 2'd2,
    ERR_INVALID   = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_PAD  = 2'd1,
    ST_FAIL = 2'd2
  } state_e;

  typedef enum logic {
    OP_DATA = 1'b0,
    OP_END  = 1'b1
  } op_e;

  // controller -> datapath
  typedef struct packed {
    logic take;      // decode the accepted input item
    logic pad_step;  // emit the next padding zero or end-of-row marker
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_free;   // output register empty or being drained
    logic starts_pad;  // current input is an end marker that needs padding
    logic makes_error; // current input raises an error
    logic pad_more;    // row not yet filled
  } status_t;

endpackage

// ===== sv/u8u32_ctrl.sv =====
// ----------------------------------------------------------------------------
// u8u32_ctrl: controller
// Sequences normal decoding, padding bursts and the sticky error state.
// ----------------------------------------------------------------------------
module u8u32_ctrl import u8u32_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.take     = 1'b0;
    cmd_o.pad_step = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        in_ready_o = status_i.slot_free;
        if (in_valid_i && status_i.slot_free) begin
          cmd_o.take = 1'b1;
          if (status_i.makes_error) begin
            state_d = ST_FAIL;
          end else if (status_i.starts_pad) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd_o.pad_step = status_i.slot_free;
        if (status_i.slot_free && !status_i.pad_more) begin
          state_d = ST_RUN;
        end
      end
      ST_FAIL: begin
        // stuck: swallow every transfer until reset
        in_ready_o = 1'b1;
      end
      default: begin
        state_d = ST_FAIL;
      end
    endcase
  end

endmodule

// ===== sv/u8u32_datapath.sv =====
// ----------------------------------------------------------------------------
// u8u32_datapath: decode state, row width register and output register
// Assembles code points from UTF-8 bytes and forms at most one result per command.
// ----------------------------------------------------------------------------
module u8u32_datapath import u8u32_pkg::*; #(
  parameter int unsigned ROW_WIDTH_BOUND = RowWidthMax
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CountW-1:0]  cfg_wdata_i,
  input  logic               op_i,
  input  logic [ByteW-1:0]   code_unit_i,
  input  logic               out_ready_i,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  output logic               out_valid_o,
  output logic [1:0]         kind_o,
  output logic [PointW-1:0]  code_point_o,
  output logic [1:0]         error_code_o,
  output logic [ByteW-1:0]   error_detail_o,
  output logic               last_o
);

  localparam logic [CountW-1:0] Bound = CountW'(ROW_WIDTH_BOUND);

  logic [CountW-1:0] row_width_q;
  logic [CountW-1:0] points_q, points_d;
  logic [1:0]        owed_q, owed_d;
  logic [PointW-1:0] partial_q, partial_d;
  logic [ByteW-1:0]  lead_q, lead_d;

  logic              out_valid_q;
  kind_e             kind_q, kind_d;
  logic [PointW-1:0] cp_q, cp_d;
  err_e              ec_q, ec_d;
  logic [ByteW-1:0]  det_q, det_d;
  logic              last_q, last_d;
  logic              load;

  logic [CountW-1:0] width;
  logic              row_full;
  logic [PointW-1:0] shifted;
  logic [1:0]        owed_dec;
  logic              err_now;

  assign width    = (row_width_q > Bound) ? Bound : row_width_q;
  assign row_full = (points_q >= width);
  assign shifted  = {partial_q[PointW-7:0], code_unit_i[5:0]};
  assign owed_dec = owed_q - 2'd1;

  always_comb begin
    points_d  = points_q;
    owed_d    = owed_q;
    partial_d = partial_q;
    lead_d    = lead_q;
    load      = 1'b0;
    err_now   = 1'b0;
    kind_d    = KIND_POINT;
    cp_d      = '0;
    ec_d      = ERR_NONE;
    det_d     = '0;
    last_d    = 1'b1;

    if (cmd_i.pad_step) begin
      load = 1'b1;
      if (!row_full) begin
        kind_d   = KIND_PAD;
        last_d   = 1'b0;
        points_d = points_q + CountW'(1);
      end else begin
        kind_d    = KIND_EOR;
        points_d  = '0;
        partial_d = '0;
      end
    end else if (op_i == OP_END) begin
      load = 1'b1;
      if (owed_q != 2'd0) begin
        err_now = 1'b1;
        ec_d    = ERR_TRUNCATED;
        det_d   = lead_q;
      end else if (!row_full) begin
        kind_d   = KIND_PAD;
        last_d   = 1'b0;
        points_d = points_q + CountW'(1);
      end else begin
        kind_d    = KIND_EOR;
        points_d  = '0;
        partial_d = '0;
      end
    end else if (owed_q != 2'd0) begin
      partial_d = shifted;
      owed_d    = owed_dec;
      if (owed_dec == 2'd0) begin
        load = 1'b1;
        if (row_full) begin
          err_now = 1'b1;
          ec_d    = ERR_TOO_MANY;
          det_d   = ByteW'(points_q);
        end else begin
          cp_d      = shifted;
          points_d  = points_q + CountW'(1);
          partial_d = '0;
        end
      end
    end else begin
      lead_d = code_unit_i;
      priority casez (code_unit_i)
        8'b0???????: begin
          load = 1'b1;
          partial_d = PointW'(code_unit_i);
          if (row_full) begin
            err_now = 1'b1;
            ec_d    = ERR_TOO_MANY;
            det_d   = ByteW'(points_q);
          end else begin
            cp_d      = PointW'(code_unit_i);
            points_d  = points_q + CountW'(1);
            partial_d = '0;
          end
        end
        8'b110?????: begin
          partial_d = PointW'(code_unit_i[4:0]);
          owed_d    = 2'd1;
        end
        8'b1110????: begin
          partial_d = PointW'(code_unit_i[3:0]);
          owed_d    = 2'd2;
        end
        8'b11110???: begin
          partial_d = PointW'(code_unit_i[2:0]);
          owed_d    = 2'd3;
        end
        default: begin
          load    = 1'b1;
          err_now = 1'b1;
          if (row_full) begin
            ec_d  = ERR_TOO_MANY;
            det_d = ByteW'(points_q);
          end else begin
            ec_d  = ERR_INVALID;
            det_d = code_unit_i;
          end
        end
      endcase
    end

    if (err_now) begin
      kind_d = KIND_ERROR;
      cp_d   = '0;
      last_d = 1'b1;
    end
  end

  assign status_o.slot_free   = !out_valid_q || out_ready_i;
  assign status_o.makes_error = err_now;
  assign status_o.starts_pad  = (op_i == OP_END) && (owed_q == 2'd0) && !row_full;
  assign status_o.pad_more    = !row_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= RowWidthReset;
    end else if (cfg_we_i) begin
      row_width_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q  <= '0;
      owed_q    <= '0;
      partial_q <= '0;
      lead_q    <= '0;
    end else if (cmd_i.take || cmd_i.pad_step) begin
      points_q  <= points_d;
      owed_q    <= owed_d;
      partial_q <= partial_d;
      lead_q    <= lead_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.take || cmd_i.pad_step) && load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.take || cmd_i.pad_step) && load) begin
      kind_q <= kind_d;
      cp_q   <= cp_d;
      ec_q   <= ec_d;
      det_q  <= det_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign code_point_o   = cp_q;
  assign error_code_o   = ec_q;
  assign error_detail_o = det_q;
  assign last_o         = last_q;

endmodule

// ===== sv/utf8_to_utf32_padded_rows.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf32_padded_rows: UTF-8 to UTF-32 decoder with padded rows
// Top level: controller plus datapath.
// ----------------------------------------------------------------------------
// Takes one UTF-8 byte or end-of-string marker per transfer and emits
// UTF-32 code points, each string padded with zeros up to row_width
// (capped at ROW_WIDTH_BOUND) and closed by an end-of-row marker. Data
// bytes go in at one per cycle: a byte is decoded in the cycle it arrives
// and its result lands in a single output register, so input keeps flowing
// while a result waits as long as the sink drains it in the same cycle.
// An end marker gives (row width - code points so far) padding zeros and an
// end-of-row marker, one padding zero per cycle while the output register is
// free; the controller holds off input until the end-of-row marker has been
// loaded. The first error (truncated sequence, too many code points, invalid
// lead byte) is reported once; after it every input transfer is accepted and
// dropped until reset. Continuation bytes and overlong forms are not checked.
// row_width is written via cfg_we_i/cfg_wdata_i and must only change while
// the block is idle.
// ----------------------------------------------------------------------------
module utf8_to_utf32_padded_rows import u8u32_pkg::*; #(
  parameter int unsigned ROW_WIDTH_BOUND = RowWidthMax
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [CountW-1:0]  cfg_wdata_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [ByteW-1:0]   code_unit_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic [PointW-1:0]  code_point_o,
  output logic [1:0]         error_code_o,
  output logic [ByteW-1:0]   error_detail_o,
  output logic               last_o
);

  cmd_t    cmd;
  status_t status;

  // state machine: run / padding burst / sticky failure
  u8u32_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // decode state, row width, output register
  u8u32_datapath #(
    .ROW_WIDTH_BOUND (ROW_WIDTH_BOUND)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .op_i           (op_i),
    .code_unit_i    (code_unit_i),
    .out_ready_i    (out_ready_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .kind_o         (kind_o),
    .code_point_o   (code_point_o),
    .error_code_o   (error_code_o),
    .error_detail_o (error_detail_o),
    .last_o         (last_o)
  );

endmodule

// ===== sv/u8u32_checker.sv =====
// ----------------------------------------------------------------------------
// u8u32_checker: port-level assertions
// Observes the top level's ports and flags result-stream violations.
// ----------------------------------------------------------------------------
module u8u32_checker import u8u32_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [1:0]        kind_o,
  input logic [PointW-1:0] code_point_o,
  input logic [1:0]        error_code_o,
  input logic [ByteW-1:0]  error_detail_o,
  input logic              last_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o)
      && $stable(code_point_o) && $stable(error_code_o) && $stable(last_o))
    else $error("stalled result changed");

  // error fields only on error results
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_ERROR |-> error_code_o == ERR_NONE
      && error_detail_o == '0)
    else $error("error fields set on non-error result");

  // padding never last, everything else always last
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (kind_o != KIND_PAD)))
    else $error("last flag inconsistent with kind");

  // nothing follows an error
  a_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && kind_o == KIND_ERROR |=> !out_valid_o)
    else $error("result after error");

endmodule

bind utf8_to_utf32_padded_rows u8u32_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .kind_o         (kind_o),
  .code_point_o   (code_point_o),
  .error_code_o   (error_code_o),
  .error_detail_o (error_detail_o),
  .last_o         (last_o)
);

// ===== tb/sv/utf8_to_utf32_padded_rows_tb.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf32_padded_rows_tb: self-checking bench for the padded row decoder
// Drives UTF-8 bytes and end-of-string markers through the input channel and
// predicts every code point, padding zero, end-of-row marker and error in a
// local decoder model. Each output transfer is compared field by field with
// the oldest prediction. Both channels idle at random; row_width is changed
// between phases while the block is quiet.
// ----------------------------------------------------------------------------
module utf8_to_utf32_padded_rows_tb import u8u32_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WidthBound  = RowWidthMax;
  localparam int          QuietCycles = 80;      // longest end marker: 64 results
  localparam int          CycleLimit  = 600000;
  localparam int          RandomUnits = 60;

  // one output transfer as the decoder should produce it
  typedef struct {
    kind_e             kind;
    logic [PointW-1:0] point;
    err_e              code;
    logic [ByteW-1:0]  detail;
    logic              last;
  } decoded_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CountW-1:0]  cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic               op_i        = 1'b0;
  logic [ByteW-1:0]   code_unit_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         kind_o;
  logic [PointW-1:0]  code_point_o;
  logic [1:0]         error_code_o;
  logic [ByteW-1:0]   error_detail_o;
  logic               last_o;

  utf8_to_utf32_padded_rows #(
    .ROW_WIDTH_BOUND(WidthBound)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .code_unit_i    (code_unit_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .code_point_o   (code_point_o),
    .error_code_o   (error_code_o),
    .error_detail_o (error_detail_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Decoder model: a private copy of the register and the per-string state.
  // --------------------------------------------------------------------------
  logic [CountW-1:0] row_width_cfg = RowWidthReset;
  logic [CountW-1:0] points_in_row = '0;
  logic [1:0]        bytes_left    = '0;
  logic [PointW-1:0] point_acc     = '0;
  logic [ByteW-1:0]  lead_unit     = '0;
  logic              decoder_stuck = 1'b0;

  decoded_t awaited_results [$];   // predictions not yet matched by a transfer

  int error_count = 0;
  int cycle_count = 0;
  bit src_idle_on  = 1'b1;          // sender inserts gaps while set
  bit sink_idle_on = 1'b1;          // receiver stalls while set

  function automatic int active_width();
    return (row_width_cfg > WidthBound) ? WidthBound : int'(row_width_cfg);
  endfunction

  task automatic push_result(kind_e kind, logic [PointW-1:0] point, err_e code,
                             logic [ByteW-1:0] detail, logic last);
    decoded_t r;
    r.kind   = kind;
    r.point  = point;
    r.code   = code;
    r.detail = detail;
    r.last   = last;
    awaited_results.push_back(r);
  endtask

  // First error only; afterwards the decoder swallows everything.
  task automatic raise_error(err_e code, logic [ByteW-1:0] detail);
    decoder_stuck = 1'b1;
    push_result(KIND_ERROR, '0, code, detail, 1'b1);
  endtask

  // Sequence complete: emit it, or flag overflow if the row is already full.
  task automatic complete_point();
    if (int'(points_in_row) >= active_width()) begin
      raise_error(ERR_TOO_MANY, {2'b00, points_in_row});
    end else begin
      push_result(KIND_POINT, point_acc, ERR_NONE, '0, 1'b1);
      points_in_row = points_in_row + 1'b1;
      point_acc     = '0;
    end
  endtask

  task automatic decode_utf8_unit(op_e op, logic [ByteW-1:0] unit);
    int n;
    if (decoder_stuck) return;
    if (op == OP_END) begin
      if (bytes_left != 0) begin
        raise_error(ERR_TRUNCATED, lead_unit);
        return;
      end
      for (n = int'(points_in_row); n < active_width(); n++)
        push_result(KIND_PAD, '0, ERR_NONE, '0, 1'b0);
      push_result(KIND_EOR, '0, ERR_NONE, '0, 1'b1);
      points_in_row = '0;
      point_acc     = '0;
      return;
    end
    // any byte after a lead counts as a continuation, low six bits only
    if (bytes_left != 0) begin
      point_acc  = {point_acc[PointW-7:0], unit[5:0]};
      bytes_left = bytes_left - 1'b1;
      if (bytes_left == 0) complete_point();
      return;
    end
    lead_unit = unit;
    casez (unit)
      8'b0???????: begin
        point_acc = {13'd0, unit};
        complete_point();
      end
      8'b110?????: begin
        point_acc  = {16'd0, unit[4:0]};
        bytes_left = 2'd1;
      end
      8'b1110????: begin
        point_acc  = {17'd0, unit[3:0]};
        bytes_left = 2'd2;
      end
      8'b11110???: begin
        point_acc  = {18'd0, unit[2:0]};
        bytes_left = 2'd3;
      end
      default: begin
        // stray continuation or 11111xxx where a lead belongs
        if (int'(points_in_row) >= active_width())
          raise_error(ERR_TOO_MANY, {2'b00, points_in_row});
        else
          raise_error(ERR_INVALID, unit);
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // One input transfer. Payload changes at the falling edge; acceptance is
  // seen at the rising edge, where the model is advanced. Valid stays high
  // across back-to-back transfers when no gap is drawn.
  task automatic send_unit(op_e op, logic [ByteW-1:0] unit);
    int gap;
    if ($urandom_range(0, 15) == 0) src_idle_on = !src_idle_on;
    gap = src_idle_on ? $urandom_range(0, 9) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    op_i        = op;
    code_unit_i = unit;
    while (1) begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    decode_utf8_unit(op, unit);
  endtask

  function automatic logic [ByteW-1:0] random_lead(int nbytes);
    case (nbytes)
      1:       return 8'($urandom_range(0, 127));
      2:       return 8'hC0 | 8'($urandom_range(0, 31));
      3:       return 8'hE0 | 8'($urandom_range(0, 15));
      default: return 8'hF0 | 8'($urandom_range(0, 7));
    endcase
  endfunction

  // lead bytes that can never start a sequence: 10xxxxxx or 11111xxx
  function automatic logic [ByteW-1:0] random_bad_lead();
    if ($urandom_range(0, 1) == 0)
      return 8'h80 | 8'($urandom_range(0, 63));
    return 8'hF8 | 8'($urandom_range(0, 7));
  endfunction

  // well-formed lead with arbitrary continuation bytes (the block ignores
  // their top bits, so all 256 values are fair game)
  task automatic send_random_point(int nbytes);
    send_unit(OP_DATA, random_lead(nbytes));
    repeat (nbytes - 1) send_unit(OP_DATA, 8'($urandom_range(0, 255)));
  endtask

  // Drop valid, let every prediction arrive, then give an end marker that
  // might still be padding time to finish before anything else happens.
  task automatic wait_for_quiet();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  task automatic write_row_width(logic [CountW-1:0] width);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = width;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    row_width_cfg = width;
  endtask

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------

  // Receiver: per result draws a stall, then holds ready until a transfer.
  always begin : result_sink
    int stall;
    if ($urandom_range(0, 15) == 0) sink_idle_on = !sink_idle_on;
    stall = sink_idle_on ? $urandom_range(0, 9) : 0;
    @(negedge clk_i);
    if (stall != 0) begin
      out_ready_i = 1'b0;
      repeat (stall) @(negedge clk_i);
    end
    out_ready_i = 1'b1;
    while (1) begin
      @(posedge clk_i);
      if (out_valid_o) break;
    end
  end

  always @(posedge clk_i) begin : result_check
    decoded_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: unexpected result kind=%0d point=%h code=%0d detail=%h last=%0b",
                   $realtime, kind_o, code_point_o, error_code_o, error_detail_o, last_o);
      end else begin
        want = awaited_results.pop_front();
        if (kind_o !== want.kind || code_point_o !== want.point ||
            error_code_o !== want.code || error_detail_o !== want.detail ||
            last_o !== want.last) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: mismatch exp kind=%0d point=%h code=%0d detail=%h last=%0b",
                     $realtime, want.kind, want.point, want.code, want.detail, want.last,
                     " / got kind=%0d point=%h code=%0d detail=%h last=%0b",
                     kind_o, code_point_o, error_code_o, error_detail_o, last_o);
        end
      end
    end
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("utf8_to_utf32_padded_rows test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset width is 63: one point then 62 pads and the end-of-row marker.
  task automatic test_reset_width();
    send_unit(OP_DATA, 8'h41);
    send_unit(OP_END, 8'h00);
    wait_for_quiet();
  endtask

  // Every sequence length at both ends of its range, plus a continuation
  // whose top bits are 11 and an end marker with all code_unit bits set.
  task automatic test_sequence_lengths();
    logic [ByteW-1:0] units [$];
    write_row_width(6'd8);
    units = {8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF};
    foreach (units[i]) send_unit(OP_DATA, units[i]);
    send_unit(OP_END, 8'h00);
    units = {8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80,
             8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hC3, 8'hFF};
    foreach (units[i]) send_unit(OP_DATA, units[i]);
    send_unit(OP_END, 8'hFF);
    wait_for_quiet();
  endtask

  // Full row with a pending sequence: the width in force when the last byte
  // lands decides, so widening the row in between lets the point through.
  // Then a zero-width row, which is just the end-of-row marker.
  task automatic test_row_edges();
    write_row_width(6'd1);
    send_unit(OP_DATA, 8'h78);
    send_unit(OP_DATA, 8'hE2);
    wait_for_quiet();
    write_row_width(6'd2);
    send_unit(OP_DATA, 8'h82);
    send_unit(OP_DATA, 8'hAC);
    send_unit(OP_END, 8'h5A);
    wait_for_quiet();
    write_row_width(6'd0);
    send_unit(OP_END, 8'hA5);
    wait_for_quiet();
  endtask

  // Well-formed strings that never overflow, in phases of different widths.
  task automatic test_random_strings();
    int sent, phase, width, len, cap;
    sent  = 0;
    phase = 0;
    while (sent < RandomUnits) begin
      case (phase % 4)
        0:       width = $urandom_range(1, 8);
        1:       width = 0;
        2:       width = $urandom_range(9, 62);
        default: width = 63;
      endcase
      write_row_width(6'(width));
      // about 15 items per phase
      for (int phase_sent = 0; phase_sent < 15 && sent < RandomUnits; ) begin
        cap = (width < 5) ? width : 5;
        if (width <= 8 && $urandom_range(0, 3) == 0)
          len = width;                      // exactly full row
        else
          len = $urandom_range(0, cap);
        repeat (len) begin
          int nbytes;
          nbytes = $urandom_range(1, 4);
          send_random_point(nbytes);
          phase_sent += nbytes;
          sent       += nbytes;
        end
        send_unit(OP_END, 8'($urandom_range(0, 255)));
        phase_sent++;
        sent++;
      end
      wait_for_quiet();
      phase++;
    end
  endtask

  // One error per run, since it is sticky until reset; the seed picks which.
  // Everything sent after it must produce nothing.
  task automatic test_sticky_error();
    int scenario, width, fill, nbytes;
    scenario = $urandom_range(0, 3);
    width    = (scenario >= 2) ? $urandom_range(0, 4) : $urandom_range(1, 8);
    fill     = (scenario >= 2) ? width : $urandom_range(0, width - 1);
    write_row_width(6'(width));
    repeat (fill) send_random_point(1);
    case (scenario)
      0: begin
        // end marker in the middle of a sequence
        nbytes = $urandom_range(2, 4);
        send_unit(OP_DATA, random_lead(nbytes));
        repeat ($urandom_range(0, nbytes - 2)) send_unit(OP_DATA, 8'($urandom_range(0, 255)));
        send_unit(OP_END, 8'($urandom_range(0, 255)));
      end
      1:       send_unit(OP_DATA, random_bad_lead());
      2:       send_random_point($urandom_range(1, 4));  // point past the full row
      default: send_unit(OP_DATA, random_bad_lead());    // bad lead at a full row
    endcase
    repeat (12) send_unit(op_e'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    wait_for_quiet();
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_width();
    test_sequence_lengths();
    test_row_edges();
    test_random_strings();
    test_sticky_error();

    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("utf8_to_utf32_padded_rows test passed");
    end else begin
      $display("utf8_to_utf32_padded_rows test failed");
    end
    $finish;
  end

endmodule
